// ----- hdl/endstop_calibrate_center_fsm_assert.svh -----
// Assertion macros for the end-stop calibrate-and-center controller.
`ifndef ENDSTOP_CALIBRATE_CENTER_FSM_ASSERT_SVH
`define ENDSTOP_CALIBRATE_CENTER_FSM_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ESCF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("escf: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ESCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("escf: next-cycle check failed");

`endif

// ----- hdl/escf_pkg.sv -----
// Package with the word types of the end-stop calibrate-and-center controller.
package escf_pkg;

    localparam int unsigned TimeW        = 32;
    localparam int unsigned PhaseW       = 3;
    localparam int unsigned BlinkW       = 8;
    localparam logic [TimeW-1:0] TimeoutReset = 32'd10000;

    typedef struct packed {
        logic [TimeW-1:0] now_ticks;
        logic             back_pressed;
        logic             fwd_pressed;
    } t_escf_in;

    typedef struct packed {
        logic              drive_forward;
        logic              drive_backward;
        logic              led_level;
        logic [PhaseW-1:0] phase_out;
    } t_escf_out;

endpackage

// ----- hdl/endstop_calibrate_center_fsm.sv -----
// End-stop calibrate-and-center controller: top level.
//
// Input channel: one word per controller iteration (tick time and the two end
// switch bits), moved on i_in_valid with o_in_stall low. Output channel: one
// word per input word (motor drive bits, LED level, phase), moved on
// o_out_valid with i_out_stall low.
// An accepted word enters the input register; its result is computed from that
// register and the controller state and is loaded into the output register
// when the word advances, which a receiver stall can hold off. Throughput: one
// word per cycle while the receiver does not stall; the state update (subtract,
// compares, adds) lies between the input and output registers. The timeout
// register is loaded by i_cfg_wr_en / i_cfg_wr_data; the user must write it
// only while idle, which the block itself does not enforce. Reset (i_rst_n low,
// synchronous) empties both registers, sets the phase to unknown, clears the
// timing state, sets the LED pin high and the timeout to 10000 ticks.
// When the receiver stalls, the output word holds; the input register still
// takes one more word, then o_in_stall rises until the output word is taken.
`include "endstop_calibrate_center_fsm_assert.svh"

module endstop_calibrate_center_fsm
    import escf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [TimeW-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    input  t_escf_in         i_in_word,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_escf_out        o_out_word,
    input  logic             i_out_stall
);

    typedef enum logic [PhaseW-1:0] {
        PH_UNKNOWN   = 3'd0,
        PH_HOMEBACK  = 3'd1,
        PH_HOMEFWD   = 3'd2,
        PH_SPEEDFWD  = 3'd3,
        PH_SPEEDBACK = 3'd4,
        PH_MOVING    = 3'd5,
        PH_MIDDLE    = 3'd6,
        PH_ERROR     = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        MOT_IDLE = 2'd0,
        MOT_FWD  = 2'd1,
        MOT_BACK = 2'd2
    } t_motor;

    logic             r_s1_valid;
    t_escf_in         r_s1_word;
    logic             r_out_valid;
    t_escf_out        r_out_word;
    logic [TimeW-1:0] r_timeout;

    t_phase           r_phase,       n_phase;
    logic [TimeW-1:0] r_start,       n_start;
    logic [TimeW-1:0] r_target,      n_target;
    logic [TimeW-1:0] r_fwd_travel,  n_fwd_travel;
    logic [TimeW-1:0] r_back_travel, n_back_travel;
    logic [BlinkW-1:0] r_blink,      n_blink;
    logic             r_led,         n_led;
    t_motor           r_motor,       n_motor;

    logic             s1_adv;
    logic [TimeW-1:0] elapsed;
    logic             timed_out;
    logic             bk, fw;
    t_escf_out        n_out_word;

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign bk         = r_s1_word.back_pressed;
    assign fw         = r_s1_word.fwd_pressed;
    assign elapsed    = r_s1_word.now_ticks - r_start;
    assign timed_out  = elapsed > r_timeout;

    always_comb begin
        n_phase       = r_phase;
        n_start       = r_start;
        n_target      = r_target;
        n_fwd_travel  = r_fwd_travel;
        n_back_travel = r_back_travel;
        n_blink       = r_blink;
        n_led         = r_led;
        n_motor       = r_motor;
        if (bk && fw) begin
            // both switches: error, and blink in the same step
            n_phase = PH_ERROR;
            n_motor = MOT_IDLE;
            if (r_blink == '0) begin
                n_led = ~r_led;
            end
            n_blink = r_blink + 1'b1;
        end else begin
            case (r_phase)
                PH_UNKNOWN: begin
                    n_led = 1'b1;
                    if (bk) begin
                        n_phase = PH_HOMEFWD;
                        n_motor = MOT_FWD;
                    end else begin
                        n_phase = PH_HOMEBACK;
                        n_motor = MOT_BACK;
                    end
                    n_start = r_s1_word.now_ticks;
                end
                PH_HOMEBACK: begin
                    if (timed_out) begin
                        n_phase = PH_ERROR;
                        n_motor = MOT_IDLE;
                    end else if (bk) begin
                        n_phase = PH_SPEEDFWD;
                        n_start = r_s1_word.now_ticks;
                        n_motor = MOT_FWD;
                    end
                end
                PH_HOMEFWD: begin
                    if (timed_out) begin
                        n_phase = PH_ERROR;
                        n_motor = MOT_IDLE;
                    end else if (fw) begin
                        n_phase = PH_SPEEDBACK;
                        n_start = r_s1_word.now_ticks;
                        n_motor = MOT_BACK;
                    end
                end
                PH_SPEEDFWD: begin
                    if (timed_out) begin
                        n_phase = PH_ERROR;
                        n_motor = MOT_IDLE;
                    end else if (fw) begin
                        n_fwd_travel = elapsed;
                        n_motor      = MOT_BACK;
                        if (r_back_travel == '0) begin
                            n_phase = PH_SPEEDBACK;
                            n_start = r_s1_word.now_ticks;
                        end else begin
                            n_phase  = PH_MOVING;
                            n_target = r_s1_word.now_ticks + (r_back_travel >> 1);
                        end
                    end
                end
                PH_SPEEDBACK: begin
                    if (timed_out) begin
                        n_phase = PH_ERROR;
                        n_motor = MOT_IDLE;
                    end else if (bk) begin
                        n_back_travel = elapsed;
                        n_motor       = MOT_FWD;
                        if (r_fwd_travel == '0) begin
                            n_phase = PH_SPEEDFWD;
                            n_start = r_s1_word.now_ticks;
                        end else begin
                            n_phase  = PH_MOVING;
                            n_target = r_s1_word.now_ticks + (r_fwd_travel >> 1);
                        end
                    end
                end
                PH_MOVING: begin
                    if (r_s1_word.now_ticks > r_target) begin
                        n_phase = PH_MIDDLE;
                        n_motor = MOT_IDLE;
                    end
                end
                PH_MIDDLE: begin
                    n_led = 1'b0;
                end
                default: begin
                    // error: toggle the LED each time the blink counter wraps
                    if (r_blink == '0) begin
                        n_led = ~r_led;
                    end
                    n_blink = r_blink + 1'b1;
                end
            endcase
        end
        n_out_word.drive_forward  = (n_motor == MOT_FWD);
        n_out_word.drive_backward = (n_motor == MOT_BACK);
        n_out_word.led_level      = n_led;
        n_out_word.phase_out      = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_timeout     <= TimeoutReset;
            r_phase       <= PH_UNKNOWN;
            r_start       <= '0;
            r_target      <= '0;
            r_fwd_travel  <= '0;
            r_back_travel <= '0;
            r_blink       <= '0;
            r_led         <= 1'b1;
            r_motor       <= MOT_IDLE;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_out_valid   <= 1'b1;
                r_phase       <= n_phase;
                r_start       <= n_start;
                r_target      <= n_target;
                r_fwd_travel  <= n_fwd_travel;
                r_back_travel <= n_back_travel;
                r_blink       <= n_blink;
                r_led         <= n_led;
                r_motor       <= n_motor;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: load on acceptance or advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_word <= i_in_word;
        end
        if (s1_adv) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ESCF_ASSERT_NOW(a_no_dual_drive, o_out_valid,
        !(o_out_word.drive_forward && o_out_word.drive_backward))
    `ESCF_ASSERT_NOW(a_error_idle, o_out_valid && (o_out_word.phase_out == PH_ERROR),
        !o_out_word.drive_forward && !o_out_word.drive_backward)
    `ESCF_ASSERT_NEXT(a_error_sticky, r_phase == PH_ERROR, r_phase == PH_ERROR)
    `ESCF_ASSERT_NOW(a_stall_only_full, o_in_stall, r_s1_valid && r_out_valid)

endmodule

// ----- sim/endstop_calibrate_center_fsm_tb.sv -----
// Self-checking testbench for the end-stop calibrate-and-center controller.
`timescale 1ns / 1ps

module endstop_calibrate_center_fsm_tb;
    import escf_pkg::*;

    typedef enum logic [PhaseW-1:0] {
        PH_UNKNOWN, PH_HOMEBACK, PH_HOMEFWD, PH_SPEEDFWD,
        PH_SPEEDBACK, PH_MOVING, PH_MIDDLE, PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {MOTOR_IDLE, MOTOR_FWD, MOTOR_BACK} t_motor;

    typedef struct {
        logic [TimeW-1:0] now;
        bit               bk;
        bit               fw;
        bit               typed;
        t_escf_out        want;
    } t_opening_row;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned QuietFrom  = 900;
    localparam int unsigned QuietTo    = 1400;
    localparam int unsigned HoldAfter  = 300;
    localparam int unsigned HoldCycles = 120;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [TimeW-1:0] i_cfg_wr_data;
    logic             i_in_valid;
    t_escf_in         i_in_word;
    logic             o_in_stall;
    logic             o_out_valid;
    t_escf_out        o_out_word;
    logic             i_out_stall;

    // controller copy kept in step with every accepted word
    t_phase           ctl_phase;
    t_motor           motor;
    logic [TimeW-1:0] mark_ticks;
    logic [TimeW-1:0] stop_ticks;
    logic [TimeW-1:0] fwd_span;
    logic [TimeW-1:0] back_span;
    logic [BlinkW-1:0] blink_cnt;
    logic             led_pin;
    logic [TimeW-1:0] timeout_lim;

    t_escf_out        pending_out[$];
    int unsigned      cyc;
    int unsigned      fails;
    int unsigned      words_in;
    int unsigned      words_checked;
    string            route;

    endstop_calibrate_center_fsm uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .i_in_word    (i_in_word),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word),
        .i_out_stall  (i_out_stall)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    function void enter_error();
        motor     = MOTOR_IDLE;
        ctl_phase = PH_ERROR;
    endfunction

    // Advance the controller copy by one word and return the word it shows.
    function t_escf_out calc_iteration(input t_escf_in w);
        logic [TimeW-1:0] elapsed;
        t_escf_out        r;
        elapsed = w.now_ticks - mark_ticks;
        if (w.back_pressed && w.fwd_pressed)
            enter_error();
        case (ctl_phase)
            PH_UNKNOWN: begin
                led_pin = 1'b1;
                if (w.back_pressed) begin
                    ctl_phase = PH_HOMEFWD;
                    motor     = MOTOR_FWD;
                end else begin
                    ctl_phase = PH_HOMEBACK;
                    motor     = MOTOR_BACK;
                end
                mark_ticks = w.now_ticks;
            end
            PH_HOMEBACK: begin
                if (elapsed > timeout_lim) begin
                    enter_error();
                end else if (w.back_pressed) begin
                    ctl_phase  = PH_SPEEDFWD;
                    mark_ticks = w.now_ticks;
                    motor      = MOTOR_FWD;
                end
            end
            PH_HOMEFWD: begin
                if (elapsed > timeout_lim) begin
                    enter_error();
                end else if (w.fwd_pressed) begin
                    ctl_phase  = PH_SPEEDBACK;
                    mark_ticks = w.now_ticks;
                    motor      = MOTOR_BACK;
                end
            end
            PH_SPEEDFWD: begin
                if (elapsed > timeout_lim) begin
                    enter_error();
                end else if (w.fwd_pressed) begin
                    fwd_span = elapsed;
                    motor    = MOTOR_BACK;
                    // a zero span counts as unmeasured: time the other way again
                    if (back_span == '0) begin
                        ctl_phase  = PH_SPEEDBACK;
                        mark_ticks = w.now_ticks;
                    end else begin
                        ctl_phase  = PH_MOVING;
                        stop_ticks = w.now_ticks + (back_span >> 1);
                    end
                end
            end
            PH_SPEEDBACK: begin
                if (elapsed > timeout_lim) begin
                    enter_error();
                end else if (w.back_pressed) begin
                    back_span = elapsed;
                    motor     = MOTOR_FWD;
                    if (fwd_span == '0) begin
                        ctl_phase  = PH_SPEEDFWD;
                        mark_ticks = w.now_ticks;
                    end else begin
                        ctl_phase  = PH_MOVING;
                        stop_ticks = w.now_ticks + (fwd_span >> 1);
                    end
                end
            end
            PH_MOVING: begin
                if (w.now_ticks > stop_ticks) begin
                    ctl_phase = PH_MIDDLE;
                    motor     = MOTOR_IDLE;
                end
            end
            PH_MIDDLE: led_pin = 1'b0;
            default: begin
                if (blink_cnt == '0)
                    led_pin = ~led_pin;
                blink_cnt = blink_cnt + 1'b1;
            end
        endcase
        r.drive_forward  = (motor == MOTOR_FWD);
        r.drive_backward = (motor == MOTOR_BACK);
        r.led_level      = led_pin;
        r.phase_out      = ctl_phase;
        return r;
    endfunction

    function bit take_break();
        if (cyc >= QuietFrom && cyc <= QuietTo)
            return 1'b0;
        return $urandom_range(99, 0) < 11;
    endfunction

    function logic [TimeW-1:0] pick_span(input logic [TimeW-1:0] lim);
        if (lim == '1)
            return $urandom();
        if ($urandom_range(9, 0) == 0)
            return lim;
        return $urandom_range(lim, 0);
    endfunction

    // Word for the timing phases: zero-span presses that keep the measurement
    // looping, plus ignored switches and in-range waits, the waits most common.
    function t_escf_in loop_word();
        t_escf_in    w;
        int unsigned roll;
        logic        target_fwd;
        w          = '0;
        roll       = $urandom_range(99, 0);
        target_fwd = (ctl_phase == PH_SPEEDFWD);
        w.now_ticks = mark_ticks + ((roll < 30) ? '0 : pick_span(timeout_lim));
        if (roll < 30) begin
            w.fwd_pressed  = target_fwd;
            w.back_pressed = !target_fwd;
        end else if (roll < 45) begin
            w.fwd_pressed  = !target_fwd;
            w.back_pressed = target_fwd;
        end
        return w;
    endfunction

    task automatic drive_word(input t_escf_in w, input bit typed, input t_escf_out want);
        t_escf_out got;
        @(negedge i_clk);
        while (take_break()) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = w;
        do
            @(posedge i_clk);
        while (o_in_stall);
        got = calc_iteration(w);
        pending_out.push_back(typed ? want : got);
        words_in++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_out.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [TimeW-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        timeout_lim = v;
    endtask

    // Receiver: random stalls, one long hold once traffic is flowing.
    initial begin : receiver
        int unsigned hold_left;
        bit          hold_done;
        hold_left   = 0;
        hold_done   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else if (!hold_done && words_checked >= HoldAfter) begin
                i_out_stall = 1'b1;
                hold_left   = HoldCycles - 1;
                hold_done   = 1'b1;
            end else begin
                i_out_stall = take_break();
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_escf_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_checked++;
            if (pending_out.size() == 0) begin
                $error("unexpected result word %h", o_out_word);
                fails++;
            end else begin
                want = pending_out.pop_front();
                if (o_out_word.drive_forward !== want.drive_forward) begin
                    $error("drive_forward: expected %0d, got %0d",
                           want.drive_forward, o_out_word.drive_forward);
                    fails++;
                end
                if (o_out_word.drive_backward !== want.drive_backward) begin
                    $error("drive_backward: expected %0d, got %0d",
                           want.drive_backward, o_out_word.drive_backward);
                    fails++;
                end
                if (o_out_word.led_level !== want.led_level) begin
                    $error("led_level: expected %0d, got %0d",
                           want.led_level, o_out_word.led_level);
                    fails++;
                end
                if (o_out_word.phase_out !== want.phase_out) begin
                    $error("phase_out: expected %0d, got %0d",
                           want.phase_out, o_out_word.phase_out);
                    fails++;
                end
            end
        end
    end

    initial begin : stimulus
        t_opening_row     opening[7];
        logic [TimeW-1:0] lims[6];
        t_escf_in         w;
        int unsigned      steps;
        int unsigned      sw;

        // homing from a start near the top of the tick range, then a
        // zero-span measurement in each direction
        opening = '{
            '{32'hFFFF_FFF0, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, PH_HOMEBACK}},
            '{32'h0000_2700, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, PH_HOMEBACK}},
            '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, '0},
            '{32'h0000_0005, 1'b1, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, PH_SPEEDFWD}},
            '{32'h0000_2715, 1'b1, 1'b0, 1'b0, '0},
            '{32'h0000_0005, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b1, PH_SPEEDBACK}},
            '{32'h0000_0005, 1'b1, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, PH_SPEEDFWD}}
        };
        lims = '{32'hFFFF_FFFF, 32'd1, 32'd0, TimeoutReset,
                 $urandom_range(32'h00FF_FFFF, 2), 32'hFFFF_FFFF};

        cyc           = 0;
        fails         = 0;
        words_in      = 0;
        words_checked = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_in_word     = '0;

        ctl_phase   = PH_UNKNOWN;
        motor       = MOTOR_IDLE;
        mark_ticks  = '0;
        stop_ticks  = '0;
        fwd_span    = '0;
        back_span   = '0;
        blink_cnt   = '0;
        led_pin     = 1'b1;
        timeout_lim = TimeoutReset;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (opening[k]) begin
            w              = '0;
            w.now_ticks    = opening[k].now;
            w.back_pressed = opening[k].bk;
            w.fwd_pressed  = opening[k].fw;
            drive_word(w, opening[k].typed, opening[k].want);
        end

        foreach (lims[k]) begin
            drain();
            write_timeout(lims[k]);
            repeat (110) drive_word(loop_word(), 1'b0, '0);
        end

        drain();
        if ($urandom_range(1, 0) == 1) begin
            route = "measured travel, middle, then both switches";
            write_timeout($urandom_range(32'hFFFF_FFFE, 32'h0100_0000));
            while (ctl_phase == PH_SPEEDFWD || ctl_phase == PH_SPEEDBACK) begin
                if ($urandom_range(99, 0) < 35) begin
                    w              = '0;
                    w.now_ticks    = mark_ticks + $urandom_range(timeout_lim, 1);
                    w.fwd_pressed  = (ctl_phase == PH_SPEEDFWD);
                    w.back_pressed = (ctl_phase == PH_SPEEDBACK);
                end else begin
                    w = loop_word();
                end
                drive_word(w, 1'b0, '0);
            end
            steps = 0;
            while (ctl_phase == PH_MOVING && steps < 60) begin
                w              = '0;
                sw             = $urandom_range(2, 0);
                w.back_pressed = (sw == 1);
                w.fwd_pressed  = (sw == 2);
                if ((steps >= 40 || $urandom_range(99, 0) < 5) && stop_ticks != '1)
                    w.now_ticks = $urandom_range(32'hFFFF_FFFF, stop_ticks + 1);
                else if (stop_ticks == '1)
                    w.now_ticks = $urandom();
                else
                    w.now_ticks = $urandom_range(stop_ticks, 0);
                drive_word(w, 1'b0, '0);
                steps++;
            end
            repeat (60) begin
                w              = '0;
                sw             = $urandom_range(2, 0);
                w.back_pressed = (sw == 1);
                w.fwd_pressed  = (sw == 2);
                w.now_ticks    = $urandom();
                drive_word(w, 1'b0, '0);
            end
            w              = '0;
            w.now_ticks    = $urandom();
            w.back_pressed = 1'b1;
            w.fwd_pressed  = 1'b1;
            drive_word(w, 1'b1, '{1'b0, 1'b0, 1'b1, PH_ERROR});
        end else begin
            route = "travel timeout";
            write_timeout($urandom_range(100000, 1));
            repeat (50) drive_word(loop_word(), 1'b0, '0);
            w           = '0;
            w.now_ticks = mark_ticks + $urandom_range(32'hFFFF_FFFF, timeout_lim + 1);
            {w.back_pressed, w.fwd_pressed} = 2'($urandom_range(3, 0));
            drive_word(w, 1'b0, '0);
        end

        // error phase: long enough for the blink counter to wrap twice
        repeat (540) begin
            w           = '0;
            w.now_ticks = $urandom();
            {w.back_pressed, w.fwd_pressed} = 2'($urandom_range(3, 0));
            drive_word(w, 1'b0, '0);
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("Summary: %0d words sent, %0d result words checked, timeouts 0 to all-ones",
                 words_in, words_checked);
        $display("Ending: %s, final phase %0d", route, ctl_phase);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
